// ===== rtl/qspd_pkg.sv =====
package qspd_pkg;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_AMP     = 8'h26;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;

  // Escape progress: no escape, '%' seen, '%' and first digit seen.
  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_FIRST = 2'd1;
  localparam logic [1:0] ESC_SECOND = 2'd2;

  typedef enum logic [3:0] {
    MODE_START = 4'b0001,
    MODE_NAME  = 4'b0010,
    MODE_VALUE = 4'b0100,
    MODE_SKIP  = 4'b1000
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       in_value;
    logic       name_end;
    logic       pair_end;
  } out_item_t;

endpackage

// ===== rtl/qspd_parse.sv =====
module qspd_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  qspd_pkg::in_item_t item,
  output qspd_pkg::out_item_t result,
  output logic               has_result
);
  import qspd_pkg::*;

  parse_mode_t mode, mode_next;
  logic [1:0]  escape_count, escape_count_next;
  logic [3:0]  high_nibble, high_nibble_next;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    return v;
  endfunction

  logic [7:0] c;
  logic [1:0] esc_eff;
  logic [3:0] hi_eff;
  logic       dec_emit;
  logic [7:0] dec_val;
  logic [1:0] dec_esc;
  logic [3:0] dec_hi;
  logic       flush_emit;
  logic [7:0] flush_val;
  logic       tail_emit;
  logic [7:0] tail_val;
  logic       emit, name_end, pair_end, inval;
  logic [7:0] val;
  parse_mode_t mode_byte;
  logic [1:0]  esc_byte;
  logic [3:0]  hi_byte;

  assign c = item.in_byte;

  // A new item starts with no escape pending.
  assign esc_eff = (mode == MODE_START) ? ESC_NONE : escape_count;
  assign hi_eff  = (mode == MODE_START) ? 4'd0 : high_nibble;

  always_comb begin
    dec_emit = 1'b0;
    dec_val  = 8'd0;
    dec_esc  = ESC_NONE;
    dec_hi   = hi_eff;
    if (esc_eff == ESC_FIRST) begin
      dec_hi  = hex_value(c);
      dec_esc = ESC_SECOND;
    end else if (esc_eff == ESC_SECOND) begin
      dec_val  = {hi_eff, hex_value(c)};
      dec_emit = 1'b1;
      dec_hi   = 4'd0;
    end else if (c == CHAR_PERCENT) begin
      dec_esc = ESC_FIRST;
      dec_hi  = 4'd0;
    end else if (c == CHAR_PLUS) begin
      dec_val  = CHAR_SPACE;
      dec_emit = 1'b1;
    end else begin
      dec_val  = c;
      dec_emit = 1'b1;
    end
  end

  // Release of a pending escape at a segment end, before this byte.
  assign flush_emit = (escape_count == ESC_FIRST) || (escape_count == ESC_SECOND);
  assign flush_val  = (escape_count == ESC_SECOND) ? {high_nibble, 4'd0} : 8'd0;

  always_comb begin
    mode_byte = mode;
    esc_byte  = escape_count;
    hi_byte   = high_nibble;
    emit      = 1'b0;
    val       = 8'd0;
    name_end  = 1'b0;
    pair_end  = 1'b0;
    inval     = 1'b0;
    unique case (mode)
      MODE_START: begin
        if (c == CHAR_AMP) begin
          mode_byte = MODE_START;
        end else if (c == CHAR_EQUALS) begin
          mode_byte = MODE_SKIP;
        end else begin
          mode_byte = MODE_NAME;
          esc_byte  = dec_esc;
          hi_byte   = dec_hi;
          emit      = dec_emit;
          val       = dec_val;
        end
      end
      MODE_NAME: begin
        if (c == CHAR_AMP || c == CHAR_EQUALS) begin
          emit      = flush_emit;
          val       = flush_val;
          esc_byte  = ESC_NONE;
          hi_byte   = 4'd0;
          name_end  = 1'b1;
          pair_end  = (c == CHAR_AMP);
          mode_byte = (c == CHAR_AMP) ? MODE_START : MODE_VALUE;
        end else begin
          esc_byte = dec_esc;
          hi_byte  = dec_hi;
          emit     = dec_emit;
          val      = dec_val;
        end
      end
      MODE_VALUE: begin
        inval = 1'b1;
        if (c == CHAR_AMP) begin
          emit      = flush_emit;
          val       = flush_val;
          esc_byte  = ESC_NONE;
          hi_byte   = 4'd0;
          pair_end  = 1'b1;
          mode_byte = MODE_START;
        end else begin
          esc_byte = dec_esc;
          hi_byte  = dec_hi;
          emit     = dec_emit;
          val      = dec_val;
        end
      end
      MODE_SKIP: begin
        if (c == CHAR_AMP) mode_byte = MODE_START;
      end
      default: begin
        mode_byte = MODE_START;
      end
    endcase
  end

  // Close the open item on the last byte; a pending escape never coexists
  // with a byte emitted by this step.
  assign tail_emit = (esc_byte == ESC_FIRST) || (esc_byte == ESC_SECOND);
  assign tail_val  = (esc_byte == ESC_SECOND) ? {hi_byte, 4'd0} : 8'd0;

  logic       fin_emit, fin_name_end, fin_pair_end;
  logic [7:0] fin_val;

  always_comb begin
    fin_emit          = emit;
    fin_val           = val;
    fin_name_end      = name_end;
    fin_pair_end      = pair_end;
    mode_next         = mode_byte;
    escape_count_next = esc_byte;
    high_nibble_next  = hi_byte;
    if (item.last) begin
      if (mode_byte == MODE_NAME || mode_byte == MODE_VALUE) begin
        if (tail_emit) begin
          fin_emit = 1'b1;
          fin_val  = tail_val;
        end
        fin_pair_end = 1'b1;
        if (mode_byte == MODE_NAME) fin_name_end = 1'b1;
      end
      mode_next         = MODE_START;
      escape_count_next = ESC_NONE;
      high_nibble_next  = 4'd0;
    end
  end

  assign result.out_byte   = fin_emit ? fin_val : 8'd0;
  assign result.byte_valid = fin_emit;
  assign result.in_value   = inval;
  assign result.name_end   = fin_name_end;
  assign result.pair_end   = fin_pair_end;
  assign has_result        = fin_emit || fin_name_end || fin_pair_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_START;
      escape_count <= ESC_NONE;
      high_nibble  <= 4'd0;
    end else if (step) begin
      mode         <= mode_next;
      escape_count <= escape_count_next;
      high_nibble  <= high_nibble_next;
    end
  end

endmodule

// ===== rtl/qspd_out_reg.sv =====
module qspd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  qspd_pkg::out_item_t result,
  output logic                slot_open,
  output logic                out_valid,
  input  logic                out_ready,
  output qspd_pkg::out_item_t out_data
);
  import qspd_pkg::*;

  out_item_t held;
  logic      full;

  assign slot_open = !full || out_ready;
  assign out_valid = full;
  assign out_data  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  // Hold the request until taken; load only into an open slot.
  always_ff @(posedge clk) begin
    if (load) held <= result;
  end

endmodule

// ===== rtl/query_string_pair_decoder_core.sv =====
// channel | handshake            | payload
// in      | in_valid / in_ready  | in_data  (in_byte, last)
// out     | out_valid / out_ready| out_data (out_byte, byte_valid, in_value, name_end, pair_end)
//
// One byte per cycle sustained while out_ready holds; results pass stage, then output register.
// Bytes that end in no result are consumed without using the output slot.
// The parse state (mode, escape progress, pending nibble) updates once per byte.
// rst is synchronous: it empties both registers and returns the parser to item start.
// A stalled output holds its request; in_ready falls only when that stall backs up.
module query_string_pair_decoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  qspd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output qspd_pkg::out_item_t out_data
);
  import qspd_pkg::*;

  in_item_t  stage;
  logic      stage_full;
  logic      advance;
  logic      slot_open;
  logic      has_result;
  out_item_t result;

  assign advance  = stage_full && (!has_result || slot_open);
  assign in_ready = !stage_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_full <= 1'b0;
    end else if (in_ready) begin
      stage_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) stage <= in_data;
  end

  qspd_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item       (stage),
    .result     (result),
    .has_result (has_result)
  );

  qspd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && has_result),
    .result    (result),
    .slot_open (slot_open),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.byte_valid || out_data.name_end || out_data.pair_end))
    else $error("empty result delivered");

  a_name_side: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.in_value && out_data.name_end))
    else $error("name end marked on value side");

  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.byte_valid) |-> (out_data.out_byte == 8'd0))
    else $error("out_byte set without byte_valid");

  a_no_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output ready");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import qspd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  query_string_pair_decoder_core i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Decoder state mirrored by the predictor
  parse_mode_t dec_mode = MODE_START;
  logic [1:0] esc_seen = ESC_NONE;
  logic [3:0] esc_high = 4'h0;

  out_item_t pending_results[$];
  int mismatch_count = 0;
  int bytes_sent = 0;
  int burst_left = 0;
  bit tx_gaps_on = 1'b0;
  bit rx_stall_on = 1'b0;
  logic [15:0] ready_bits = 16'hFFFF;
  int pattern_left = 0;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "f") d = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") d = c - "A" + 8'd10;
    return d[3:0];
  endfunction

  // Feed one byte of a name or value through the escape decoder.
  function automatic void absorb_char(input logic [7:0] c, inout logic emit,
                                      inout logic [7:0] val);
    case (esc_seen)
      ESC_FIRST: begin
        esc_high = hex_nibble(c);
        esc_seen = ESC_SECOND;
      end
      ESC_SECOND: begin
        val = {esc_high, hex_nibble(c)};
        emit = 1'b1;
        esc_seen = ESC_NONE;
        esc_high = 4'h0;
      end
      default: begin
        if (c == CHAR_PERCENT) begin
          esc_seen = ESC_FIRST;
          esc_high = 4'h0;
        end else begin
          val = (c == CHAR_PLUS) ? CHAR_SPACE : c;
          emit = 1'b1;
          esc_seen = ESC_NONE;
        end
      end
    endcase
  endfunction

  // Release a pending escape at a segment end, missing nibbles as zero.
  function automatic void flush_escape(inout logic emit, inout logic [7:0] val);
    if (esc_seen == ESC_FIRST) begin
      val = 8'h00;
      emit = 1'b1;
    end else if (esc_seen == ESC_SECOND) begin
      val = {esc_high, 4'h0};
      emit = 1'b1;
    end
    esc_seen = ESC_NONE;
    esc_high = 4'h0;
  endfunction

  function automatic logic predict_decoded_byte(input in_item_t item, output out_item_t res);
    logic emit;
    logic nend;
    logic pend;
    logic inval;
    logic [7:0] val;
    logic [7:0] c;
    emit = 1'b0;
    nend = 1'b0;
    pend = 1'b0;
    inval = 1'b0;
    val = 8'h00;
    c = item.in_byte;
    case (dec_mode)
      MODE_START: begin
        if (c == CHAR_EQUALS) begin
          dec_mode = MODE_SKIP;
        end else if (c != CHAR_AMP) begin
          dec_mode = MODE_NAME;
          esc_seen = ESC_NONE;
          esc_high = 4'h0;
          absorb_char(c, emit, val);
        end
      end
      MODE_NAME: begin
        if (c == CHAR_AMP) begin
          flush_escape(emit, val);
          nend = 1'b1;
          pend = 1'b1;
          dec_mode = MODE_START;
        end else if (c == CHAR_EQUALS) begin
          flush_escape(emit, val);
          nend = 1'b1;
          dec_mode = MODE_VALUE;
        end else begin
          absorb_char(c, emit, val);
        end
      end
      MODE_VALUE: begin
        inval = 1'b1;
        if (c == CHAR_AMP) begin
          flush_escape(emit, val);
          pend = 1'b1;
          dec_mode = MODE_START;
        end else begin
          absorb_char(c, emit, val);
        end
      end
      default: begin
        if (c == CHAR_AMP) dec_mode = MODE_START;
      end
    endcase
    // Close the open item as if '&' followed.
    if (item.last) begin
      if (dec_mode == MODE_NAME) begin
        flush_escape(emit, val);
        nend = 1'b1;
        pend = 1'b1;
      end else if (dec_mode == MODE_VALUE) begin
        flush_escape(emit, val);
        pend = 1'b1;
      end
      dec_mode = MODE_START;
      esc_seen = ESC_NONE;
      esc_high = 4'h0;
    end
    res.out_byte = emit ? val : 8'h00;
    res.byte_valid = emit;
    res.in_value = inval;
    res.name_end = nend;
    res.pair_end = pend;
    return emit || nend || pend;
  endfunction

  // Receiver: rotate a random ready pattern, reloaded when its run counter runs out.
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      ready_bits = ($urandom_range(0, 3) == 0) ? 16'($urandom & $urandom)
                                                : 16'($urandom | $urandom);
      pattern_left = $urandom_range(16, 64);
    end
    pattern_left--;
    ready_bits = {ready_bits[0], ready_bits[15:1]};
    out_ready <= !rx_stall_on || ready_bits[0];
  end

  task automatic report_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected request expected none actual %p", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        report_field("out_byte", want.out_byte, out_data.out_byte);
        report_field("byte_valid", 8'(want.byte_valid), 8'(out_data.byte_valid));
        report_field("in_value", 8'(want.in_value), 8'(out_data.in_value));
        report_field("name_end", 8'(want.name_end), 8'(out_data.name_end));
        report_field("pair_end", 8'(want.pair_end), 8'(out_data.pair_end));
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_query_byte(input logic [7:0] b, input logic is_last);
    in_item_t item;
    out_item_t res;
    int gap;
    item.in_byte = b;
    item.last = is_last;
    if (tx_gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (predict_decoded_byte(item, res)) pending_results.push_back(res);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit end_query);
    for (int i = 0; i < s.len(); i++)
      send_query_byte(s[i], end_query && (i == s.len() - 1));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_escape_decoding();
    send_text("%41+=%fF&", 1'b0);
    drain_results();
  endtask

  task automatic test_raw_extremes();
    send_query_byte(8'h00, 1'b0);
    send_query_byte(8'hFF, 1'b0);
    send_query_byte(8'h80, 1'b1);
    drain_results();
  endtask

  task automatic test_empty_and_skipped_items();
    send_text("&&=x&", 1'b0);
    drain_results();
  endtask

  task automatic test_cut_short_escapes();
    send_text("k%4=%", 1'b1);
    drain_results();
  endtask

  task automatic test_short_pairs();
    // empty value, then a bare name closed by the last byte
    send_text("v=&n", 1'b1);
    // '%' and '=' inside a value act as escape digits
    send_text("w=%%=", 1'b1);
    drain_results();
  endtask

  function automatic logic [7:0] random_text_char(input bit in_value_part);
    string hex_digits = "0123456789abcdefABCDEF";
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: c = CHAR_PERCENT;
      1: c = CHAR_PLUS;
      2, 3: c = hex_digits[$urandom_range(0, 21)];
      4: c = in_value_part ? CHAR_EQUALS : "g";
      5: begin
        c = 8'($urandom);
        if (c == CHAR_AMP || c == CHAR_EQUALS) c = "z";
      end
      default: c = 8'("a" + $urandom_range(0, 25));
    endcase
    return c;
  endfunction

  task automatic test_random_queries(input int target);
    logic [7:0] query[$];
    int start_count;
    int n_items;
    int len;
    start_count = bytes_sent;
    while (bytes_sent - start_count < target) begin
      query.delete();
      n_items = $urandom_range(1, 5);
      for (int i = 0; i < n_items; i++) begin
        if (i > 0) query.push_back(CHAR_AMP);
        case ($urandom_range(0, 9))
          0: ;
          1: begin
            query.push_back(CHAR_EQUALS);
            len = $urandom_range(0, 4);
            repeat (len) query.push_back(random_text_char(1'b1));
          end
          default: begin
            len = $urandom_range(1, 6);
            repeat (len) query.push_back(random_text_char(1'b0));
            if ($urandom_range(0, 4) != 0) begin
              query.push_back(CHAR_EQUALS);
              len = $urandom_range(0, 8);
              repeat (len) query.push_back(random_text_char(1'b1));
            end
          end
        endcase
      end
      if ($urandom_range(0, 7) == 0) query.push_back(CHAR_AMP);
      if (query.size() == 0) query.push_back("a");
      foreach (query[i]) send_query_byte(query[i], i == query.size() - 1);
    end
    drain_results();
  endtask

  task automatic test_random_noise(input int target);
    logic [7:0] b;
    repeat (target) begin
      b = 8'($urandom);
      case ($urandom_range(0, 11))
        0: b = CHAR_AMP;
        1: b = CHAR_EQUALS;
        2: b = CHAR_PERCENT;
        default: ;
      endcase
      send_query_byte(b, $urandom_range(0, 15) == 0);
    end
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_escape_decoding();
    test_raw_extremes();
    test_empty_and_skipped_items();
    test_cut_short_escapes();
    test_short_pairs();
    tx_gaps_on = 1'b1;
    rx_stall_on = 1'b1;
    test_random_queries(1100);
    tx_gaps_on = 1'b0;
    rx_stall_on = 1'b0;
    test_random_queries(150);
    tx_gaps_on = 1'b0;
    rx_stall_on = 1'b1;
    test_random_queries(150);
    tx_gaps_on = 1'b1;
    test_random_noise(250);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
